>>> rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and codes for the transfer session sequencer: phase and
// status encodings, event codes, register map and the structs passed
// between the configuration block, the sequencer core and the top level.
// ----------------------------------------------------------------------------
package tss_pkg;

    // field widths
    localparam int MODE_W    = 4;
    localparam int TIME_W    = 48;
    localparam int COUNT_W   = 16;
    localparam int LIMIT_W   = 24;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = 2;

    // event codes carried on mode
    localparam logic [MODE_W-1:0] MODE_START     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_LINK_UP   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_LINK_DOWN = 4'd2;
    localparam logic [MODE_W-1:0] MODE_BACK      = 4'd3;
    localparam logic [MODE_W-1:0] MODE_TICK      = 4'd4;
    localparam logic [MODE_W-1:0] MODE_CONFIRM   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_CHUNK_ACK = 4'd6;
    localparam logic [MODE_W-1:0] MODE_PAIR_IN   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_SET_TOTAL = 4'd8;

    // register indexes (byte address 4*index)
    localparam logic [REG_IDX_W-1:0] REG_CONFIRM_TIMEOUT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DONE_HOLD       = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ERROR_HOLD      = 2'd2;

    // register reset values
    localparam logic [LIMIT_W-1:0] CONFIRM_TIMEOUT_RST = 24'd30000;
    localparam logic [LIMIT_W-1:0] DONE_HOLD_RST       = 24'd3000;
    localparam logic [LIMIT_W-1:0] ERROR_HOLD_RST      = 24'd3000;

    // session phase
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LINK    = 3'd1,
        PH_INPUT   = 3'd2,
        PH_CONFIRM = 3'd3,
        PH_SENDING = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    // outcome of a pairing input event
    typedef enum logic [2:0] {
        ST_NONE        = 3'd0,
        ST_WRONG_STATE = 3'd1,
        ST_ACCEPTED    = 3'd2,
        ST_LOCKED      = 3'd3,
        ST_REJECTED    = 3'd4
    } status_t;

    // one request as held in the input register
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TIME_W-1:0]  now_ms;
        logic               code_expired;
        logic               code_matches;
        logic               code_locked;
        logic [COUNT_W-1:0] chunk_total;
    } item_t;

    // one result as held in the output register
    typedef struct packed {
        logic    changed;
        phase_t  state_now;
        status_t input_status;
        logic    make_code;
    } result_t;

    // timing limits from the register block
    typedef struct packed {
        logic [LIMIT_W-1:0] confirm_timeout_ms;
        logic [LIMIT_W-1:0] done_hold_ms;
        logic [LIMIT_W-1:0] error_hold_ms;
    } cfg_t;

endpackage

>>> rtl/transfer_session_sequencer.sv
// ----------------------------------------------------------------------------
// transfer_session_sequencer
// Seven-phase transfer session sequencer, one timestamped event per request.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the in_valid/in_ready channel (mode, now_ms, pairing
//   flags, chunk_total); each event yields exactly one result on the
//   out_valid/out_ready channel (changed, state_now, input_status,
//   make_code), in order.
//   An accepted request is held in the input register; the session state
//   and the output register update together when it advances, which waits
//   while a result is held in the output register and out_ready is low.
//   Throughput is one request per cycle while out_ready is high; the state
//   update is a single pass of compare, 48-bit subtract and counter logic
//   between the input and output registers.
//   When out_ready is low the output register holds its result and the
//   input register takes one more request, then in_ready drops until the
//   result is taken.
//   Reset (rst_n low) empties both registers, puts the session in idle with
//   cleared counts and entry time, and loads the default timing limits.
//   The user writes the timing limits over the APB port only while no
//   request is in flight; the block makes no check. pready is always high.
// ----------------------------------------------------------------------------
module transfer_session_sequencer
    import tss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // event channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [MODE_W-1:0]  mode,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic               code_expired,
    input  logic               code_matches,
    input  logic               code_locked,
    input  logic [COUNT_W-1:0] chunk_total,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               changed,
    output logic [2:0]         state_now,
    output logic [2:0]         input_status,
    output logic               make_code,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;
    result_t res;
    cfg_t    cfg;
    logic    advance;
    logic    in_take;

    // register block
    tss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // session state machine
    tss_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // handshake control
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input request register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.mode         <= mode;
            item_reg.now_ms       <= now_ms;
            item_reg.code_expired <= code_expired;
            item_reg.code_matches <= code_matches;
            item_reg.code_locked  <= code_locked;
            item_reg.chunk_total  <= chunk_total;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign changed      = res_reg.changed;
    assign state_now    = res_reg.state_now;
    assign input_status = res_reg.input_status;
    assign make_code    = res_reg.make_code;

endmodule

>>> rtl/tss_cfg.sv
// ----------------------------------------------------------------------------
// tss_cfg
// APB-style register block holding the three timing limits.
// ----------------------------------------------------------------------------
module tss_cfg
    import tss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [LIMIT_W-1:0]   confirm_timeout_reg;
    logic [LIMIT_W-1:0]   done_hold_reg;
    logic [LIMIT_W-1:0]   error_hold_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_timeout_reg <= CONFIRM_TIMEOUT_RST;
            done_hold_reg       <= DONE_HOLD_RST;
            error_hold_reg      <= ERROR_HOLD_RST;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_CONFIRM_TIMEOUT)
            begin
                confirm_timeout_reg <= pwdata[LIMIT_W-1:0];
            end
            if (reg_idx == REG_DONE_HOLD)
            begin
                done_hold_reg <= pwdata[LIMIT_W-1:0];
            end
            if (reg_idx == REG_ERROR_HOLD)
            begin
                error_hold_reg <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    // read data mux, unmapped addresses read zero
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_CONFIRM_TIMEOUT: prdata = {{(PDATA_W-LIMIT_W){1'b0}}, confirm_timeout_reg};
            REG_DONE_HOLD:       prdata = {{(PDATA_W-LIMIT_W){1'b0}}, done_hold_reg};
            REG_ERROR_HOLD:      prdata = {{(PDATA_W-LIMIT_W){1'b0}}, error_hold_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.confirm_timeout_ms = confirm_timeout_reg;
    assign cfg.done_hold_ms       = done_hold_reg;
    assign cfg.error_hold_ms      = error_hold_reg;

endmodule

>>> rtl/tss_core.sv
// ----------------------------------------------------------------------------
// tss_core
// Session state machine: phase, entry timestamp and chunk counters, updated
// once per request, with the result computed from the same request.
// ----------------------------------------------------------------------------
module tss_core
    import tss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [TIME_W-1:0]  entered_at_reg;
    logic [TIME_W-1:0]  entered_at_next;
    logic [COUNT_W-1:0] sent_count_reg;
    logic [COUNT_W-1:0] sent_count_next;
    logic [COUNT_W-1:0] total_count_reg;
    logic [COUNT_W-1:0] total_count_next;

    logic [LIMIT_W-1:0] limit;
    logic [TIME_W-1:0]  age;
    logic               timed_out;
    logic [COUNT_W-1:0] sent_inc;

    // time since the phase was entered, against the limit of this phase
    always_comb
    begin
        unique case (phase_reg)
            PH_CONFIRM: limit = cfg.confirm_timeout_ms;
            PH_DONE:    limit = cfg.done_hold_ms;
            default:    limit = cfg.error_hold_ms;
        endcase
    end

    assign age       = item.now_ms - entered_at_reg;
    assign timed_out = (age >= {{(TIME_W-LIMIT_W){1'b0}}, limit});

    // saturating chunk count
    assign sent_inc = (sent_count_reg == {COUNT_W{1'b1}}) ? sent_count_reg
                                                         : sent_count_reg + 1'b1;

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        entered_at_next  = entered_at_reg;
        sent_count_next  = sent_count_reg;
        total_count_next = total_count_reg;
        priority if (item.mode == MODE_LINK_DOWN)
        begin
            if (phase_reg != PH_IDLE)
            begin
                phase_next      = PH_ERROR;
                entered_at_next = item.now_ms;
            end
        end
        else if (item.mode == MODE_BACK)
        begin
            if (phase_reg != PH_SENDING && phase_reg != PH_IDLE)
            begin
                phase_next       = PH_IDLE;
                entered_at_next  = item.now_ms;
                sent_count_next  = '0;
                total_count_next = '0;
            end
        end
        else if (item.mode == MODE_PAIR_IN)
        begin
            if (phase_reg == PH_INPUT)
            begin
                if (item.code_matches)
                begin
                    phase_next      = PH_CONFIRM;
                    entered_at_next = item.now_ms;
                end
                else if (item.code_locked)
                begin
                    phase_next      = PH_ERROR;
                    entered_at_next = item.now_ms;
                end
            end
        end
        else if (item.mode == MODE_SET_TOTAL)
        begin
            total_count_next = item.chunk_total;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (item.mode == MODE_START)
                    begin
                        phase_next      = PH_LINK;
                        entered_at_next = item.now_ms;
                    end
                end
                PH_LINK:
                begin
                    if (item.mode == MODE_LINK_UP)
                    begin
                        phase_next      = PH_INPUT;
                        entered_at_next = item.now_ms;
                    end
                end
                PH_INPUT:
                begin
                    if (item.mode == MODE_TICK && item.code_expired)
                    begin
                        phase_next      = PH_ERROR;
                        entered_at_next = item.now_ms;
                    end
                end
                PH_CONFIRM:
                begin
                    if (item.mode == MODE_CONFIRM)
                    begin
                        phase_next      = PH_SENDING;
                        entered_at_next = item.now_ms;
                        sent_count_next = '0;
                    end
                    else if (item.mode == MODE_TICK && timed_out)
                    begin
                        phase_next      = PH_ERROR;
                        entered_at_next = item.now_ms;
                    end
                end
                PH_SENDING:
                begin
                    if (item.mode == MODE_CHUNK_ACK)
                    begin
                        sent_count_next = sent_inc;
                        if (sent_inc >= total_count_reg)
                        begin
                            phase_next      = PH_DONE;
                            entered_at_next = item.now_ms;
                        end
                    end
                end
                PH_DONE, PH_ERROR:
                begin
                    if (item.mode == MODE_TICK && timed_out)
                    begin
                        phase_next       = PH_IDLE;
                        entered_at_next  = item.now_ms;
                        sent_count_next  = '0;
                        total_count_next = '0;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // result of this request
    always_comb
    begin
        res.changed   = (phase_next != phase_reg);
        res.state_now = phase_next;
        res.make_code = (item.mode == MODE_LINK_UP) && (phase_reg == PH_LINK);
        if (item.mode != MODE_PAIR_IN)
        begin
            res.input_status = ST_NONE;
        end
        else if (phase_reg != PH_INPUT)
        begin
            res.input_status = ST_WRONG_STATE;
        end
        else if (item.code_matches)
        begin
            res.input_status = ST_ACCEPTED;
        end
        else if (item.code_locked)
        begin
            res.input_status = ST_LOCKED;
        end
        else
        begin
            res.input_status = ST_REJECTED;
        end
    end

    // session state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            entered_at_reg  <= '0;
            sent_count_reg  <= '0;
            total_count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            entered_at_reg  <= entered_at_next;
            sent_count_reg  <= sent_count_next;
            total_count_reg <= total_count_next;
        end
    end

`ifndef ASSERT_OFF
    // the reported phase is the one held after the request
    a_phase_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> phase_reg == $past(res.state_now))
        else $error("phase register does not follow reported state");

    // a code is requested only when leaving await link
    a_make_code_src: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.make_code |-> phase_reg == PH_LINK && res.state_now == PH_INPUT)
        else $error("make_code outside the link-up transition");

    // accepted pairing input always lands in await confirm
    a_accept_dest: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.input_status == ST_ACCEPTED |-> res.state_now == PH_CONFIRM)
        else $error("accepted pairing input did not reach await confirm");

    // nothing has been sent before the sending phase is reached
    a_sent_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE || phase_reg == PH_LINK || phase_reg == PH_INPUT
        || phase_reg == PH_CONFIRM |-> sent_count_reg == '0)
        else $error("chunk count nonzero before sending");
`endif

endmodule
